// ===== rtl/svm_pkg.sv =====
// sample voice mixer: shared types, field widths, function codes and csr indexes
// no dependencies; svm_if, svm_scale and the top level use this package, svm_ram does not
`default_nettype none

package svm_pkg;

   // request and result payload types
   typedef logic        [1:0]  func_type;
   typedef logic        [13:0] saddr_type;
   typedef logic signed [15:0] sample_type;
   typedef logic        [2:0]  sound_type;

   // configuration types
   typedef logic [14:0] gain_type;
   typedef logic [28:0] region_type;
   typedef logic [2:0]  csr_idx_type;

   // per-voice playback position
   typedef logic [14:0] pos_type;

   // function codes, the last code is ignored
   localparam func_type FUNC_LOAD  = 2'd0;
   localparam func_type FUNC_TRIG  = 2'd1;
   localparam func_type FUNC_FRAME = 2'd2;

   // register map
   localparam csr_idx_type CSR_GAIN    = 3'd0;
   localparam csr_idx_type CSR_REGION0 = 3'd1;

   localparam int NUM_SOUNDS = 5;
   localparam gain_type GAIN_RESET = 15'd4915;
   localparam int MIX_LIMIT = 32767;

   // region fields
   localparam int START_LSB = 0;
   localparam int START_MSB = 13;
   localparam int LEN_LSB   = 14;
   localparam int LEN_MSB   = 28;

endpackage

`default_nettype wire

// ===== rtl/svm_if.sv =====
// sample voice mixer: request and result channel interfaces (valid/ready)
// depends on svm_pkg for the payload types
`default_nettype none

interface svm_req_if;
   logic                  valid;
   logic                  ready;
   svm_pkg::func_type     func;
   svm_pkg::saddr_type    sample_addr;
   svm_pkg::sample_type   sample_value;
   svm_pkg::sound_type    trig_sound;

   modport source (output valid, output func, output sample_addr, output sample_value,
                   output trig_sound, input ready);
   modport sink   (input valid, input func, input sample_addr, input sample_value,
                   input trig_sound, output ready);
endinterface

interface svm_rsp_if;
   logic                  valid;
   logic                  ready;
   svm_pkg::sample_type   left_out;
   svm_pkg::sample_type   right_out;

   modport source (output valid, output left_out, output right_out, input ready);
   modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

`default_nettype wire

// ===== rtl/svm_ram.sv =====
// sample voice mixer: generic single-write, single-read ram with registered read
// no dependencies
`default_nettype none

module svm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata_ff
);

   logic [WIDTH-1:0] mem [0:DEPTH-1];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/svm_scale.sv =====
// sample voice mixer: shared gain unit, sign-magnitude multiply by q0.15 gain
// truncating toward zero, result registered; depends on svm_pkg
`default_nettype none

module svm_scale (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_vld,
   input  svm_pkg::sample_type sample,
   input  svm_pkg::gain_type   gain,
   output logic                term_vld_ff,
   output svm_pkg::sample_type term_ff
);
   import svm_pkg::*;

   logic [15:0] mag;
   logic [30:0] prod;
   logic [15:0] quot;
   sample_type  term_in;

   always_comb begin
      mag     = sample[15] ? 16'(-sample) : 16'(sample);
      prod    = 31'(mag) * 31'(gain);
      quot    = prod[30:15];
      term_in = sample[15] ? sample_type'(-quot) : sample_type'(quot);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         term_vld_ff <= 1'b0;
      end else begin
         term_vld_ff <= in_vld;
      end
      term_ff <= term_in;
   end

endmodule

`default_nettype wire

// ===== rtl/sample_voice_mixer_top.sv =====
// sample voice mixer top level: voice table, sequencer, sample store and mix accumulator
// depends on svm_pkg, svm_if, svm_ram and svm_scale
//
//   channel   dir   handshake        payload
//   req_chan  in    valid/ready      func, sample_addr, sample_value, trig_sound
//   rsp_chan  out   valid/ready      left_out, right_out (equal)
//   csr_*     in    csr_we only      csr_index, csr_wdata
//
// a load is written to the store on acceptance, a trigger scans for a slot
// a frame walks the voices, one voice per cycle through the store read
// port and the single gain multiplier, then pipeline drain and clamp
// reset clears voices, config registers and the sequencer; store contents undefined
// req ready only while idle; a finished frame waits in the result register
// a new frame stalls in the emit state while the previous result is still unread
`default_nettype none

module sample_voice_mixer_top #(
   parameter int MAX_VOICES   = 8,
   parameter int SAMPLE_DEPTH = 16384
) (
   input  logic                  clock,
   input  logic                  reset,
   svm_req_if.sink               req_chan,
   svm_rsp_if.source             rsp_chan,
   input  logic                  csr_we,
   input  svm_pkg::csr_idx_type  csr_index,
   input  svm_pkg::region_type   csr_wdata
);
   import svm_pkg::*;

   localparam int ADDR_W       = $clog2(SAMPLE_DEPTH);
   localparam int VIDX_W       = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
   localparam int MIX_W        = 17 + $clog2(MAX_VOICES);
   localparam int REM_W        = 22;
   localparam int REDUCE_STEPS = 6;
   localparam logic [VIDX_W-1:0] LAST_VOICE = VIDX_W'(MAX_VOICES - 1);
   localparam logic signed [MIX_W-1:0] LIM_POS = MIX_W'(MIX_LIMIT);
   localparam logic signed [MIX_W-1:0] LIM_NEG = -MIX_W'(MIX_LIMIT);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_TRIG  = 5'b00010,
      S_MIX   = 5'b00100,
      S_DRAIN = 5'b01000,
      S_EMIT  = 5'b10000
   } state_type;

   // store address modulo the depth: restoring subtract, the sum stays below 64 depths
   function automatic logic [ADDR_W-1:0] store_addr(input logic [15:0] x);
      logic [REM_W-1:0] r;
      r = REM_W'(x);
      for (int k = REDUCE_STEPS - 1; k >= 0; k--) begin
         if (r >= (REM_W'(SAMPLE_DEPTH) << k)) begin
            r = r - (REM_W'(SAMPLE_DEPTH) << k);
         end
      end
      return r[ADDR_W-1:0];
   endfunction

   // sequencer and voice table
   state_type           state_ff, state_in;
   logic [VIDX_W-1:0]   cnt_ff, cnt_in;
   logic                drain_ff, drain_in;
   sound_type           trig_id_ff, trig_id_in;
   logic                active_ff [0:MAX_VOICES-1];
   logic                active_in [0:MAX_VOICES-1];
   sound_type           sound_ff  [0:MAX_VOICES-1];
   sound_type           sound_in  [0:MAX_VOICES-1];
   pos_type             pos_ff    [0:MAX_VOICES-1];
   pos_type             pos_in    [0:MAX_VOICES-1];

   // config registers
   gain_type            gain_ff;
   region_type          region_ff [0:NUM_SOUNDS-1];

   // mix datapath
   logic signed [MIX_W-1:0] mix_ff, mix_in;
   logic                rd_vld_ff;
   logic                rd_en;
   logic [ADDR_W-1:0]   rd_addr;
   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   logic [15:0]         rd_data;
   logic                term_vld;
   sample_type          term;

   // result register
   logic                rsp_vld_ff, rsp_vld_in;
   sample_type          rsp_data_ff, rsp_data_in;

   logic                req_take;
   logic                rsp_free;
   region_type          cur_region;
   pos_type             pos_next;
   sample_type          clamped;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_take       = req_chan.valid && req_chan.ready;
   assign rsp_free       = !rsp_vld_ff || rsp_chan.ready;

   assign rsp_chan.valid     = rsp_vld_ff;
   assign rsp_chan.left_out  = rsp_data_ff;
   assign rsp_chan.right_out = rsp_data_ff;

   // region of the voice under the counter, read fresh at every frame
   assign cur_region = (sound_ff[cnt_ff] < sound_type'(NUM_SOUNDS)) ?
                       region_ff[sound_ff[cnt_ff]] : '0;
   assign pos_next   = pos_ff[cnt_ff] + 15'd1;

   // loads go straight into the store on acceptance
   assign wr_en   = req_take && (req_chan.func == FUNC_LOAD);
   assign wr_addr = store_addr({2'b00, req_chan.sample_addr});

   // one voice read per mix cycle
   assign rd_en   = (state_ff == S_MIX) && active_ff[cnt_ff];
   assign rd_addr = store_addr(16'(cur_region[START_MSB:START_LSB]) + 16'(pos_ff[cnt_ff]));

   svm_ram #(
      .WIDTH (16),
      .DEPTH (SAMPLE_DEPTH)
   ) u_store (
      .clock    (clock),
      .we       (wr_en),
      .waddr    (wr_addr),
      .wdata    (req_chan.sample_value),
      .re       (rd_en),
      .raddr    (rd_addr),
      .rdata_ff (rd_data)
   );

   svm_scale u_scale (
      .clock       (clock),
      .reset       (reset),
      .in_vld      (rd_vld_ff),
      .sample      (sample_type'(rd_data)),
      .gain        (gain_ff),
      .term_vld_ff (term_vld),
      .term_ff     (term)
   );

   // clamp to the symmetric limit
   always_comb begin
      priority if (mix_ff > LIM_POS) begin
         clamped = sample_type'(MIX_LIMIT);
      end else if (mix_ff < LIM_NEG) begin
         clamped = -sample_type'(MIX_LIMIT);
      end else begin
         clamped = mix_ff[15:0];
      end
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      drain_in    = drain_ff;
      trig_id_in  = trig_id_ff;
      mix_in      = mix_ff;
      rsp_vld_in  = rsp_vld_ff;
      rsp_data_in = rsp_data_ff;
      for (int v = 0; v < MAX_VOICES; v++) begin
         active_in[v] = active_ff[v];
         sound_in[v]  = sound_ff[v];
         pos_in[v]    = pos_ff[v];
      end

      // result leaves when taken
      if (rsp_chan.ready) begin
         rsp_vld_in = 1'b0;
      end

      // accumulate terms as they come out of the gain unit
      if (term_vld) begin
         mix_in = mix_ff + MIX_W'(term);
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               cnt_in = '0;
               unique case (req_chan.func)
                  FUNC_TRIG: begin
                     if (req_chan.trig_sound < sound_type'(NUM_SOUNDS)) begin
                        trig_id_in = req_chan.trig_sound;
                        state_in   = S_TRIG;
                     end
                  end
                  FUNC_FRAME: begin
                     mix_in   = '0;
                     state_in = S_MIX;
                  end
                  default: begin
                     // loads complete on the store write, unused code ignored
                  end
               endcase
            end
         end
         S_TRIG: begin
            // first slot that is free or plays the same sound
            if (!active_ff[cnt_ff] || (sound_ff[cnt_ff] == trig_id_ff)) begin
               active_in[cnt_ff] = 1'b1;
               sound_in[cnt_ff]  = trig_id_ff;
               pos_in[cnt_ff]    = '0;
               state_in          = S_IDLE;
            end else if (cnt_ff == LAST_VOICE) begin
               state_in = S_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_MIX: begin
            if (active_ff[cnt_ff]) begin
               pos_in[cnt_ff] = pos_next;
               // end of sound, or position wrapped
               if ((pos_next >= cur_region[LEN_MSB:LEN_LSB]) || (pos_next == '0)) begin
                  active_in[cnt_ff] = 1'b0;
               end
            end
            if (cnt_ff == LAST_VOICE) begin
               drain_in = 1'b0;
               state_in = S_DRAIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            // wait for the store read data, then for the gain unit output
            if (drain_ff) begin
               state_in = S_EMIT;
            end else begin
               drain_in = 1'b1;
            end
         end
         S_EMIT: begin
            if (rsp_free) begin
               rsp_vld_in  = 1'b1;
               rsp_data_in = clamped;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         cnt_ff     <= '0;
         drain_ff   <= 1'b0;
         rd_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         for (int v = 0; v < MAX_VOICES; v++) begin
            active_ff[v] <= 1'b0;
         end
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         drain_ff   <= drain_in;
         rd_vld_ff  <= rd_en;
         rsp_vld_ff <= rsp_vld_in;
         for (int v = 0; v < MAX_VOICES; v++) begin
            active_ff[v] <= active_in[v];
         end
      end
      trig_id_ff  <= trig_id_in;
      mix_ff      <= mix_in;
      rsp_data_ff <= rsp_data_in;
      for (int v = 0; v < MAX_VOICES; v++) begin
         sound_ff[v] <= sound_in[v];
         pos_ff[v]   <= pos_in[v];
      end
   end

   // config registers, indexes past the last region are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= GAIN_RESET;
         for (int s = 0; s < NUM_SOUNDS; s++) begin
            region_ff[s] <= '0;
         end
      end else if (csr_we) begin
         if (csr_index == CSR_GAIN) begin
            gain_ff <= csr_wdata[14:0];
         end else if (csr_index <= csr_idx_type'(NUM_SOUNDS)) begin
            region_ff[csr_index - CSR_REGION0] <= csr_wdata;
         end
      end
   end

   // a result only appears out of the emit state
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_vld_ff) |-> $past(state_ff == S_EMIT))
      else $error("result raised outside emit");

   // every gain term lands while the frame is still accumulating
   a_term_in_frame: assert property (@(posedge clock) disable iff (reset)
      term_vld |-> (state_ff == S_MIX || state_ff == S_DRAIN))
      else $error("gain term outside mix window");

   // no store read in flight once the sequencer is back to idle
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !rd_vld_ff && !term_vld)
      else $error("read pipeline busy while idle");

   // emitted mix within the clamp range
   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> (rsp_data_ff != 16'sh8000))
      else $error("result outside clamp range");

endmodule

`default_nettype wire

// ===== tb/tb_sample_voice_mixer_top.sv =====
// testbench for sample_voice_mixer_top: directed and random load, trigger and frame requests,
// results checked against a local predictor of the voice table, store and clamped mix
// depends on svm_pkg, svm_if and the rtl under rtl/
module tb_sample_voice_mixer_top;
   timeunit 1ns;
   timeprecision 1ps;

   import svm_pkg::*;

   localparam int MAX_VOICES    = 8;
   localparam int SAMPLE_DEPTH  = 16384;
   localparam int CLOCK_PERIOD  = 10;
   localparam int RESET_CYCLES  = 10;
   localparam int PHASES        = 8;
   localparam int PHASE_BUDGET  = 68;
   // a frame walks every voice and drains the pipe, allow that a few times over
   localparam int SETTLE_CYCLES = 3 * (MAX_VOICES + 4);
   localparam int CYCLE_LIMIT   = 600000;

   // function code that the block ignores
   localparam func_type FUNC_SPARE = 2'd3;
   // register indexes past the last sound region are ignored
   localparam csr_idx_type CSR_SPARE_FIRST = CSR_REGION0 + csr_idx_type'(NUM_SOUNDS);
   localparam csr_idx_type CSR_SPARE_LAST  = '1;
   localparam sound_type   LAST_SOUND      = sound_type'(NUM_SOUNDS - 1);

   // two copies of the predicted state: one advanced as requests are planned,
   // one advanced as the block accepts them
   localparam int PLANNED  = 0;
   localparam int OBSERVED = 1;

   typedef enum logic [1:0] {FILL_RANDOM, FILL_HIGH, FILL_LOW} fill_mode_type;

   typedef struct packed {
      func_type   func;
      saddr_type  sample_addr;
      sample_type sample_value;
      sound_type  trig_sound;
   } mixer_req_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                csr_we;
   csr_idx_type         csr_index;
   region_type          csr_wdata;

   svm_req_if req_bus ();
   svm_rsp_if rsp_bus ();

   sample_voice_mixer_top #(
      .MAX_VOICES   (MAX_VOICES),
      .SAMPLE_DEPTH (SAMPLE_DEPTH)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // predicted state of the block
   sample_type store_word    [2][SAMPLE_DEPTH];
   bit         store_written [SAMPLE_DEPTH];
   bit         voice_on      [2][MAX_VOICES];
   sound_type  voice_snd     [2][MAX_VOICES];
   pos_type    voice_pos     [2][MAX_VOICES];
   gain_type   gain_reg;
   region_type region_reg    [NUM_SOUNDS];

   mixer_req_type pending_requests [$];
   sample_type frame_expect [$];

   int         queued_count;
   int         accepted_count = 0;
   int         useful_count;
   int         mismatch_count = 0;
   int         cycle_count = 0;
   int         send_idle_pct;
   int         recv_stall_pct;
   fill_mode_type load_fill;

   // region register that a voice plays from, zero for an unknown sound
   function automatic region_type voice_region(int side, int v);
      if (voice_snd[side][v] <= LAST_SOUND)
         return region_reg[voice_snd[side][v]];
      return '0;
   endfunction

   // store address a voice reads next: start plus position, wrapped to the store
   function automatic saddr_type voice_addr(int side, int v);
      region_type rv;
      rv = voice_region(side, v);
      return saddr_type'(rv[START_MSB:START_LSB] + voice_pos[side][v]);
   endfunction

   // apply one request to the predicted state, returns 1 when a frame comes out
   function automatic bit mixer_step(int side, mixer_req_type r, output sample_type mix_out);
      longint     acc;
      longint     word;
      longint     mag;
      longint     term;
      region_type rv;
      pos_type    next_pos;
      int         v;
      bit         claimed;
      acc = 0;
      claimed = 1'b0;
      mix_out = '0;
      case (r.func)
         FUNC_LOAD: begin
            store_word[side][r.sample_addr] = r.sample_value;
            store_written[r.sample_addr] = 1'b1;
            return 1'b0;
         end
         FUNC_TRIG: begin
            // first slot that is free or already plays this sound, else dropped
            if (r.trig_sound <= LAST_SOUND) begin
               for (v = 0; v < MAX_VOICES && !claimed; v++) begin
                  if (!voice_on[side][v] || voice_snd[side][v] == r.trig_sound) begin
                     voice_on[side][v] = 1'b1;
                     voice_snd[side][v] = r.trig_sound;
                     voice_pos[side][v] = '0;
                     claimed = 1'b1;
                  end
               end
            end
            return 1'b0;
         end
         FUNC_FRAME: begin
            for (v = 0; v < MAX_VOICES; v++) begin
               if (voice_on[side][v]) begin
                  rv = voice_region(side, v);
                  word = store_word[side][voice_addr(side, v)];
                  mag = (word < 0) ? -word : word;
                  // magnitude times gain, so the shift truncates toward zero
                  term = (mag * longint'(gain_reg)) >> 15;
                  acc += (word < 0) ? -term : term;
                  next_pos = voice_pos[side][v] + pos_type'(1);
                  voice_pos[side][v] = next_pos;
                  if (next_pos >= rv[LEN_MSB:LEN_LSB] || next_pos == '0)
                     voice_on[side][v] = 1'b0;
               end
            end
            if (acc > MIX_LIMIT) acc = MIX_LIMIT;
            if (acc < -MIX_LIMIT) acc = -MIX_LIMIT;
            mix_out = sample_type'(acc);
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   // every field random, callers override what matters
   function automatic mixer_req_type random_fields();
      mixer_req_type r;
      r.func = func_type'($urandom_range(3));
      r.sample_addr = saddr_type'($urandom);
      r.sample_value = sample_type'($urandom);
      r.trig_sound = sound_type'($urandom_range(7));
      return r;
   endfunction

   function automatic sample_type fill_value();
      case (load_fill)
         FILL_HIGH: return sample_type'(32767);
         FILL_LOW:  return sample_type'(-32768);
         default: begin
            if ($urandom_range(7) == 0)
               return $urandom_range(1) ? sample_type'(32767) : sample_type'(-32768);
            return sample_type'($urandom);
         end
      endcase
   endfunction

   task automatic queue_request(mixer_req_type r);
      sample_type unused;
      void'(mixer_step(PLANNED, r, unused));
      if (r.func == FUNC_LOAD || r.func == FUNC_FRAME ||
          (r.func == FUNC_TRIG && r.trig_sound <= LAST_SOUND))
         useful_count++;
      pending_requests.push_back(r);
      queued_count++;
   endtask

   task automatic queue_load(saddr_type addr, sample_type value);
      mixer_req_type r;
      r = random_fields();
      r.func = FUNC_LOAD;
      r.sample_addr = addr;
      r.sample_value = value;
      queue_request(r);
   endtask

   task automatic queue_trigger(sound_type id);
      mixer_req_type r;
      r = random_fields();
      r.func = FUNC_TRIG;
      r.trig_sound = id;
      queue_request(r);
   endtask

   // a frame never reads a store word that was not loaded: load the missing ones first
   task automatic queue_frame();
      mixer_req_type r;
      int         v;
      bit         again;
      do begin
         again = 1'b0;
         for (v = 0; v < MAX_VOICES && !again; v++) begin
            if (voice_on[PLANNED][v] && !store_written[voice_addr(PLANNED, v)]) begin
               queue_load(voice_addr(PLANNED, v), fill_value());
               again = 1'b1;
            end
         end
      end while (again);
      r = random_fields();
      r.func = FUNC_FRAME;
      queue_request(r);
   endtask

   // registers change only when no request is in flight and the block has settled
   task automatic drain();
      while (accepted_count != queued_count || frame_expect.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(csr_idx_type idx, region_type value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_GAIN)
         gain_reg = value[14:0];
      else if (idx >= CSR_REGION0 && idx < CSR_SPARE_FIRST)
         region_reg[idx - CSR_REGION0] = value;
   endtask

   task automatic random_config();
      region_type value;
      saddr_type  start;
      pos_type    len;
      int         k;
      // gain low bits chosen, upper write bits random
      value = region_type'($urandom);
      case ($urandom_range(4))
         0: value[14:0] = '0;
         1: value[14:0] = '1;
         2: value[14:0] = GAIN_RESET;
         default: ;
      endcase
      write_reg(CSR_GAIN, value);
      for (k = 0; k < NUM_SOUNDS; k++) begin
         case ($urandom_range(4))
            0: start = '0;
            1: start = '1;
            2: start = saddr_type'(SAMPLE_DEPTH - 1 - $urandom_range(7));
            3: start = saddr_type'($urandom_range(63));
            default: start = saddr_type'($urandom);
         endcase
         // mostly short sounds so voices free and slots turn over
         case ($urandom_range(7))
            0: len = '0;
            1: len = '1;
            2: len = pos_type'($urandom);
            3, 4: len = pos_type'($urandom_range(8, 1));
            default: len = pos_type'($urandom_range(40, 1));
         endcase
         write_reg(CSR_REGION0 + csr_idx_type'(k), {len, start});
      end
      if ($urandom_range(3) == 0)
         write_reg(csr_idx_type'($urandom_range(CSR_SPARE_LAST, CSR_SPARE_FIRST)),
                   region_type'($urandom));
   endtask

   task automatic random_phase(int budget);
      mixer_req_type r;
      int         target;
      int         pick;
      target = useful_count + budget;
      while (useful_count < target) begin
         pick = $urandom_range(99);
         if (pick < 40) begin
            queue_frame();
         end else if (pick < 75) begin
            // now and then a sound id past the last sound
            if ($urandom_range(9) != 0)
               queue_trigger(sound_type'($urandom_range(NUM_SOUNDS - 1)));
            else
               queue_trigger(sound_type'($urandom_range(7, NUM_SOUNDS)));
         end else if (pick < 93) begin
            queue_load(saddr_type'($urandom), sample_type'($urandom));
         end else begin
            r = random_fields();
            r.func = FUNC_SPARE;
            queue_request(r);
         end
      end
   endtask

   // request driver: next pending request whenever the bus is free, random gaps
   always @(posedge clock) begin : request_driver
      mixer_req_type nxt;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            nxt = pending_requests.pop_front();
            req_bus.valid <= 1'b1;
            req_bus.func <= nxt.func;
            req_bus.sample_addr <= nxt.sample_addr;
            req_bus.sample_value <= nxt.sample_value;
            req_bus.trig_sound <= nxt.trig_sound;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // result side back-pressure
   always @(posedge clock) begin
      if (reset)
         rsp_bus.ready <= 1'b0;
      else
         rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // monitor: predict on every accepted request, check every accepted frame
   always @(posedge clock) begin : mix_monitor
      mixer_req_type seen;
      sample_type mix;
      sample_type want;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            seen.func = req_bus.func;
            seen.sample_addr = req_bus.sample_addr;
            seen.sample_value = req_bus.sample_value;
            seen.trig_sound = req_bus.trig_sound;
            accepted_count++;
            if (mixer_step(OBSERVED, seen, mix))
               frame_expect.push_back(mix);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (frame_expect.size() == 0) begin
               $display("%0t: unexpected frame, expected none, got left %0d right %0d",
                        $time, rsp_bus.left_out, rsp_bus.right_out);
               mismatch_count++;
            end else begin
               want = frame_expect.pop_front();
               if (rsp_bus.left_out !== want) begin
                  $display("%0t: left_out expected %0d, got %0d",
                           $time, want, rsp_bus.left_out);
                  mismatch_count++;
               end
               if (rsp_bus.right_out !== want) begin
                  $display("%0t: right_out expected %0d, got %0d",
                           $time, want, rsp_bus.right_out);
                  mismatch_count++;
               end
            end
         end
      end
   end

   // hard stop in case the block hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin : stimulus
      int phase;
      int v;
      int s;
      mixer_req_type r;

      // known values on every input before the first edge
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_GAIN;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.func = FUNC_LOAD;
      req_bus.sample_addr = '0;
      req_bus.sample_value = '0;
      req_bus.trig_sound = '0;
      rsp_bus.ready = 1'b0;
      queued_count = 0;
      useful_count = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      load_fill = FILL_RANDOM;
      gain_reg = GAIN_RESET;
      for (s = 0; s < NUM_SOUNDS; s++)
         region_reg[s] = '0;
      for (v = 0; v < MAX_VOICES; v++) begin
         voice_on[PLANNED][v] = 1'b0;
         voice_on[OBSERVED][v] = 1'b0;
         voice_snd[PLANNED][v] = '0;
         voice_snd[OBSERVED][v] = '0;
         voice_pos[PLANNED][v] = '0;
         voice_pos[OBSERVED][v] = '0;
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // registers at reset: every sound starts at 0 with zero length, gain about 0.15
      queue_load('0, sample_type'(-32768));
      queue_trigger('0);
      queue_frame();
      r = random_fields();
      r.func = FUNC_SPARE;
      queue_request(r);
      queue_trigger('1);
      // zero-length voice already freed, nothing plays
      queue_frame();
      drain();

      // full gain, four long sounds that wrap past the store end, sound 4 zero length
      write_reg(CSR_GAIN, region_type'(15'h7FFF));
      for (s = 0; s < NUM_SOUNDS - 1; s++)
         write_reg(CSR_REGION0 + csr_idx_type'(s), {15'd100, saddr_type'(SAMPLE_DEPTH - 4)});
      write_reg(CSR_REGION0 + csr_idx_type'(LAST_SOUND), {15'd0, 14'h3FFF});
      write_reg(CSR_SPARE_FIRST, '1);
      write_reg(CSR_SPARE_LAST, region_type'($urandom));
      queue_load('1, sample_type'(32767));

      // each round parks sound 4 in the next slot, puts sound s after it, lets 4 expire
      // and retriggers s into the freed slot: two voices per sound, all eight busy
      load_fill = FILL_HIGH;
      for (s = 0; s < NUM_SOUNDS - 1; s++) begin
         queue_trigger(LAST_SOUND);
         queue_trigger(sound_type'(s));
         queue_frame();
         queue_trigger(sound_type'(s));
      end
      // no slot free and none plays sound 4: trigger dropped
      queue_trigger(LAST_SOUND);
      // eight full-scale voices clamp high
      queue_frame();
      // voices walk past the wrap into negative words and clamp low
      load_fill = FILL_LOW;
      repeat (4) queue_frame();
      load_fill = FILL_RANDOM;

      // random phases, idling pattern rotates with the phase
      for (phase = 1; phase < PHASES; phase++) begin
         drain();
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
            default: begin send_idle_pct = 24; recv_stall_pct = 24; end
         endcase
         random_config();
         random_phase(PHASE_BUDGET);
      end
      drain();

      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
